[design/grammar_token_scanner_unit_assert.svh]
// Assertion macros used by the scanner top module.
// Each macro names its assertion and reports through $error.
`ifndef GRAMMAR_TOKEN_SCANNER_UNIT_ASSERT_SVH
`define GRAMMAR_TOKEN_SCANNER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
// Checked on every rising clock edge outside reset.
`define GTS_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Checked on every rising clock edge, reset included.
`define GTS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define GTS_ASSERT(lbl, clk, rstn, prop, msg)
`define GTS_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

[design/gts_pkg.sv]
package gts_pkg;

    // Scanner mode codes.
    localparam logic [2:0] MODE_IDLE    = 3'd0;
    localparam logic [2:0] MODE_WEIGHT  = 3'd1;
    localparam logic [2:0] MODE_IDENT   = 3'd2;
    localparam logic [2:0] MODE_LITERAL = 3'd3;
    localparam logic [2:0] MODE_ERROR   = 3'd4;

    // Token kind codes.
    localparam logic [3:0] KIND_ERROR   = 4'd0;
    localparam logic [3:0] KIND_EOF     = 4'd1;
    localparam logic [3:0] KIND_LITERAL = 4'd2;
    localparam logic [3:0] KIND_IDENT   = 4'd3;
    localparam logic [3:0] KIND_WEIGHT  = 4'd4;
    localparam logic [3:0] KIND_EQUAL   = 4'd5;
    localparam logic [3:0] KIND_SEMI    = 4'd6;
    localparam logic [3:0] KIND_BAR     = 4'd7;
    localparam logic [3:0] KIND_PLUS    = 4'd8;
    localparam logic [3:0] KIND_BANG    = 4'd9;
    localparam logic [3:0] KIND_LPAREN  = 4'd10;
    localparam logic [3:0] KIND_RPAREN  = 4'd11;
    localparam logic [3:0] KIND_LBRACK  = 4'd12;
    localparam logic [3:0] KIND_RBRACK  = 4'd13;
    localparam logic [3:0] KIND_LBRACE  = 4'd14;
    localparam logic [3:0] KIND_RBRACE  = 4'd15;

    // Characters with a meaning of their own.
    localparam logic [7:0] CH_DQUOTE     = 8'h22;
    localparam logic [7:0] CH_SQUOTE     = 8'h27;
    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;

    // One output record.
    typedef struct packed {
        logic       token_done;
        logic       has_byte;
        logic [7:0] lexeme_byte;
        logic [3:0] kind;
    } rec_t;

    // Everything one scan step decides.
    typedef struct packed {
        logic [1:0] count;
        rec_t       rec0;
        rec_t       rec1;
        logic [2:0] mode_next;
        logic       quote_dbl_next;
    } step_t;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
    endfunction

    // Punctuation kind, or KIND_ERROR for a byte that is not punctuation.
    function automatic logic [3:0] punct_kind(input logic [7:0] c);
        logic [3:0] k;
        case (c)
            8'h3D: k = KIND_EQUAL;
            8'h3B: k = KIND_SEMI;
            8'h7C: k = KIND_BAR;
            8'h2B: k = KIND_PLUS;
            8'h21: k = KIND_BANG;
            8'h28: k = KIND_LPAREN;
            8'h29: k = KIND_RPAREN;
            8'h5B: k = KIND_LBRACK;
            8'h5D: k = KIND_RBRACK;
            8'h7B: k = KIND_LBRACE;
            8'h7D: k = KIND_RBRACE;
            default: k = KIND_ERROR;
        endcase
        return k;
    endfunction

    function automatic rec_t make_rec(input logic [3:0] kind, input logic [7:0] b,
                                      input logic has, input logic done);
        rec_t r;
        r.kind        = kind;
        r.lexeme_byte = b;
        r.has_byte    = has;
        r.token_done  = done;
        return r;
    endfunction

endpackage

[design/gts_scan_step.sv]
module gts_scan_step (
    input  logic [2:0]      mode,
    input  logic            quote_dbl,
    input  logic [7:0]      ch,
    input  logic            end_of_input,
    output gts_pkg::step_t  step
);

    logic            eoi;
    logic            st_emit;
    gts_pkg::rec_t   st_rec;
    logic [2:0]      st_mode;
    logic            st_qd;
    logic [3:0]      pk;
    logic [7:0]      close_ch;

    assign eoi      = end_of_input || (ch == 8'h00);
    assign pk       = gts_pkg::punct_kind(ch);
    assign close_ch = quote_dbl ? gts_pkg::CH_DQUOTE : gts_pkg::CH_SQUOTE;

    // Decode of the byte as the start of a new token.
    always_comb begin
        st_emit = 1'b0;
        st_rec  = gts_pkg::make_rec(gts_pkg::KIND_ERROR, 8'h00, 1'b0, 1'b1);
        st_mode = gts_pkg::MODE_IDLE;
        st_qd   = quote_dbl;
        if (gts_pkg::is_space(ch)) begin
            st_emit = 1'b0;
        end else if (gts_pkg::is_digit(ch)) begin
            st_emit = 1'b1;
            st_rec  = gts_pkg::make_rec(gts_pkg::KIND_WEIGHT, ch, 1'b1, 1'b0);
            st_mode = gts_pkg::MODE_WEIGHT;
        end else if (gts_pkg::is_alpha(ch)) begin
            st_emit = 1'b1;
            st_rec  = gts_pkg::make_rec(gts_pkg::KIND_IDENT, ch, 1'b1, 1'b0);
            st_mode = gts_pkg::MODE_IDENT;
        end else if ((ch == gts_pkg::CH_DQUOTE) || (ch == gts_pkg::CH_SQUOTE)) begin
            st_mode = gts_pkg::MODE_LITERAL;
            st_qd   = (ch == gts_pkg::CH_DQUOTE);
        end else if (pk != gts_pkg::KIND_ERROR) begin
            st_emit = 1'b1;
            st_rec  = gts_pkg::make_rec(pk, 8'h00, 1'b0, 1'b1);
        end else begin
            st_emit = 1'b1;
            st_mode = gts_pkg::MODE_ERROR;
        end
    end

    // One step of the scanner: up to two records and the next mode.
    always_comb begin
        step.count          = 2'd0;
        step.rec0           = st_rec;
        step.rec1           = st_rec;
        step.mode_next      = mode;
        step.quote_dbl_next = quote_dbl;
        if (mode == gts_pkg::MODE_ERROR) begin
            if (eoi) begin
                step.mode_next = gts_pkg::MODE_IDLE;
            end
        end else if (eoi) begin
            // Close any open token, then report end of input.
            step.rec1      = gts_pkg::make_rec(gts_pkg::KIND_EOF, 8'h00, 1'b0, 1'b1);
            step.mode_next = gts_pkg::MODE_IDLE;
            case (mode)
                gts_pkg::MODE_WEIGHT: begin
                    step.rec0  = gts_pkg::make_rec(gts_pkg::KIND_WEIGHT, 8'h00, 1'b0, 1'b1);
                    step.count = 2'd2;
                end
                gts_pkg::MODE_IDENT: begin
                    step.rec0  = gts_pkg::make_rec(gts_pkg::KIND_IDENT, 8'h00, 1'b0, 1'b1);
                    step.count = 2'd2;
                end
                gts_pkg::MODE_LITERAL: begin
                    step.rec0  = gts_pkg::make_rec(gts_pkg::KIND_LITERAL, 8'h00, 1'b0, 1'b1);
                    step.count = 2'd2;
                end
                default: begin
                    step.rec0  = gts_pkg::make_rec(gts_pkg::KIND_EOF, 8'h00, 1'b0, 1'b1);
                    step.count = 2'd1;
                end
            endcase
        end else begin
            case (mode)
                gts_pkg::MODE_WEIGHT: begin
                    if (gts_pkg::is_digit(ch)) begin
                        step.rec0  = gts_pkg::make_rec(gts_pkg::KIND_WEIGHT, ch, 1'b1, 1'b0);
                        step.count = 2'd1;
                    end else begin
                        step.rec0           = gts_pkg::make_rec(gts_pkg::KIND_WEIGHT, 8'h00,
                                                                1'b0, 1'b1);
                        step.count          = st_emit ? 2'd2 : 2'd1;
                        step.mode_next      = st_mode;
                        step.quote_dbl_next = st_qd;
                    end
                end
                gts_pkg::MODE_IDENT: begin
                    if (gts_pkg::is_alpha(ch) || gts_pkg::is_digit(ch) ||
                        (ch == gts_pkg::CH_UNDERSCORE)) begin
                        step.rec0  = gts_pkg::make_rec(gts_pkg::KIND_IDENT, ch, 1'b1, 1'b0);
                        step.count = 2'd1;
                    end else begin
                        step.rec0           = gts_pkg::make_rec(gts_pkg::KIND_IDENT, 8'h00,
                                                                1'b0, 1'b1);
                        step.count          = st_emit ? 2'd2 : 2'd1;
                        step.mode_next      = st_mode;
                        step.quote_dbl_next = st_qd;
                    end
                end
                gts_pkg::MODE_LITERAL: begin
                    step.count = 2'd1;
                    if (ch == close_ch) begin
                        step.rec0      = gts_pkg::make_rec(gts_pkg::KIND_LITERAL, 8'h00,
                                                           1'b0, 1'b1);
                        step.mode_next = gts_pkg::MODE_IDLE;
                    end else begin
                        step.rec0 = gts_pkg::make_rec(gts_pkg::KIND_LITERAL, ch, 1'b1, 1'b0);
                    end
                end
                default: begin
                    // Idle, and the unused codes that act as idle.
                    step.rec0           = st_rec;
                    step.count          = st_emit ? 2'd1 : 2'd0;
                    step.mode_next      = st_mode;
                    step.quote_dbl_next = st_qd;
                end
            endcase
        end
    end

endmodule

[design/gts_rec_fifo.sv]
module gts_rec_fifo #(
    parameter int DEPTH = 4
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic [1:0]                   push_cnt,
    input  gts_pkg::rec_t                push_rec0,
    input  gts_pkg::rec_t                push_rec1,
    input  logic                         pop,
    output gts_pkg::rec_t                head,
    output logic                         not_empty,
    output logic                         room2,
    output logic [$clog2(DEPTH+1)-1:0]   count
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

    gts_pkg::rec_t    mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next, wr_ptr_plus1;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_pop;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == LAST_PTR) ? '0 : p + PTR_W'(1);
    endfunction

    assign do_pop       = pop && (count_reg != '0);
    assign wr_ptr_plus1 = ptr_inc(wr_ptr_reg);

    // Pointer and fill count update.
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        case (push_cnt)
            2'd1:    wr_ptr_next = wr_ptr_plus1;
            2'd2:    wr_ptr_next = ptr_inc(wr_ptr_plus1);
            default: wr_ptr_next = wr_ptr_reg;
        endcase
        rd_ptr_next = do_pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg + CNT_W'(push_cnt) - CNT_W'(do_pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Record storage: up to two words written per cycle.
    always_ff @(posedge aclk) begin
        if (push_cnt != 2'd0) begin
            mem_reg[wr_ptr_reg] <= push_rec0;
        end
        if (push_cnt == 2'd2) begin
            mem_reg[wr_ptr_plus1] <= push_rec1;
        end
    end

    assign head      = mem_reg[rd_ptr_reg];
    assign not_empty = (count_reg != '0);
    assign room2     = (count_reg <= CNT_W'(DEPTH - 2));
    assign count     = count_reg;

endmodule

[design/grammar_token_scanner_unit.sv]
// First record path: input register, then the record queue.
// Throughput: one input word per cycle while each word yields at most one
// record and the queue has room for two; records leave one per cycle while
// m_tready is high, and a word that closes one token and opens another pushes
// two records at once, absorbed by the record queue.
// Reset (aresetn low, synchronous): scanner idle, queue empty, no output valid.
`include "grammar_token_scanner_unit_assert.svh"

module grammar_token_scanner_unit #(
    parameter int FIFO_DEPTH = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] ch
    input  logic        s_tlast,   // end_of_input
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] lexeme_byte
    output logic [4:0]  m_tuser,   // [3:0] kind, [4] has_byte
    output logic        m_tlast    // token_done
);

    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    logic                in_vld_reg;
    logic [7:0]          in_ch_reg;
    logic                in_last_reg;
    logic [2:0]          mode_reg;
    logic                quote_dbl_reg;
    logic                consume;
    logic                room2;
    logic [1:0]          push_cnt;
    logic [CNT_W-1:0]    fifo_count;
    gts_pkg::step_t      step;
    gts_pkg::rec_t       head;
    logic [CNT_W:0]      fill_after;
    logic [CNT_W:0]      fill_limit;
    logic                err_push;
    logic                eoi_consume;
    logic                mode_idle;
    logic                pair_open;

    // The input register empties whenever the queue can take two records.
    assign consume  = in_vld_reg && room2;
    assign s_tready = !in_vld_reg || room2;

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_tready) begin
            in_vld_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_ch_reg   <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    // Scan one byte against the current mode.
    gts_scan_step u_step (
        .mode         (mode_reg),
        .quote_dbl    (quote_dbl_reg),
        .ch           (in_ch_reg),
        .end_of_input (in_last_reg),
        .step         (step)
    );

    // Scanner state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg      <= gts_pkg::MODE_IDLE;
            quote_dbl_reg <= 1'b0;
        end else if (consume) begin
            mode_reg      <= step.mode_next;
            quote_dbl_reg <= step.quote_dbl_next;
        end
    end

    assign push_cnt = consume ? step.count : 2'd0;

    // Output record queue.
    gts_rec_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push_cnt  (push_cnt),
        .push_rec0 (step.rec0),
        .push_rec1 (step.rec1),
        .pop       (m_tready),
        .head      (head),
        .not_empty (m_tvalid),
        .room2     (room2),
        .count     (fifo_count)
    );

    assign m_tdata = head.lexeme_byte;
    assign m_tuser = {head.has_byte, head.kind};
    assign m_tlast = head.token_done;

    // Terms watched by the checks below.
    assign fill_after  = (CNT_W+1)'(fifo_count) + (CNT_W+1)'(push_cnt);
    assign fill_limit  = (CNT_W+1)'(FIFO_DEPTH) + (CNT_W+1)'(m_tvalid && m_tready);
    assign err_push    = consume && (mode_reg == gts_pkg::MODE_ERROR) && (push_cnt != 2'd0);
    assign eoi_consume = consume && in_last_reg;
    assign mode_idle   = (mode_reg == gts_pkg::MODE_IDLE);
    assign pair_open   = (push_cnt == 2'd2) && !step.rec0.token_done;

    // The queue never overflows.
    `GTS_ASSERT(a_no_overflow, aclk, aresetn, fill_after <= fill_limit, "record queue overflow")
    // Nothing is reported while the scanner waits out an error.
    `GTS_ASSERT(a_error_silent, aclk, aresetn, !err_push, "record emitted in error mode")
    // End of input always returns the scanner to idle.
    `GTS_ASSERT(a_eoi_idle, aclk, aresetn, eoi_consume |=> mode_idle, "not idle after end")
    // A word with two records always begins by closing a token.
    `GTS_ASSERT(a_pair_closes, aclk, aresetn, !pair_open, "record pair without closing record")
    // Reset empties the output side.
    `GTS_ASSERT_ALWAYS(a_reset_empty, aclk, !aresetn |=> !m_tvalid, "output valid after reset")

endmodule
